// ----- src/tsc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tsc_pkg;

  localparam logic [7:0] CRC_POLY     = 8'h8C;
  localparam logic [3:0] TEMP_LSB_IDX = 4'd0;
  localparam logic [3:0] TEMP_MSB_IDX = 4'd1;
  localparam logic [3:0] CONFIG_IDX   = 4'd4;
  localparam logic [3:0] CRC_IDX      = 4'd8;
  localparam logic [3:0] IDLE_IDX     = 4'd9;

  // Resolution field of the configuration byte, bits 6..5.
  typedef enum logic [1:0] {
    RES_9BIT  = 2'b00,
    RES_10BIT = 2'b01,
    RES_11BIT = 2'b10,
    RES_12BIT = 2'b11
  } res_code_t;

  typedef struct packed {
    logic [7:0] scratch_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [15:0] temperature_raw;
    logic        check_status;
  } result_t;

  // Reflected CRC-8, one byte shifted in LSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    logic       mix;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      mix = c[0] ^ data[i];
      c   = {1'b0, c[7:1]};
      if (mix) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  // Clears the fraction bits that the chosen resolution leaves undefined.
  function automatic logic [7:0] mask_lsb(input logic [7:0] lsb, input res_code_t res);
    logic [7:0] m;
    unique case (res)
      RES_9BIT:  m = lsb & 8'hF8;
      RES_10BIT: m = lsb & 8'hFC;
      RES_11BIT: m = lsb & 8'hFE;
      RES_12BIT: m = lsb;
      default:   m = lsb;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- src/tsc_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface tsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] scratch_byte;
  logic       frame_start;

  modport source (output valid, output scratch_byte, output frame_start, input ready);
  modport sink   (input valid, input scratch_byte, input frame_start, output ready);
endinterface

interface tsc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] temperature_raw;
  logic        check_status;

  modport source (output valid, output temperature_raw, output check_status, input ready);
  modport sink   (input valid, input temperature_raw, input check_status, output ready);
endinterface

`default_nettype wire

// ----- src/tsc_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsc_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire tsc_pkg::in_item_t in_item,
  output logic                   item_valid,
  output tsc_pkg::in_item_t      item,
  input  wire logic              item_take
);
  import tsc_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // The register may refill in the same cycle that the core takes its item.
  assign in_ready   = !valid_r || item_take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- src/tsc_frame_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsc_frame_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_valid,
  input  wire tsc_pkg::in_item_t item,
  output logic                   item_take,
  output logic                   res_valid,
  output tsc_pkg::result_t       res,
  input  wire logic              res_ready
);
  import tsc_pkg::*;

  logic [7:0] crc_r, crc_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [7:0] lsb_r, lsb_nxt;
  logic [7:0] msb_r, msb_nxt;
  res_code_t  res_r, res_nxt;

  logic [3:0] idx;
  logic [7:0] crc_base;
  logic       is_crc_byte;

  // A start mark restarts the frame before this byte is looked at.
  assign idx         = item.frame_start ? TEMP_LSB_IDX : idx_r;
  assign crc_base    = item.frame_start ? 8'h00 : crc_r;
  assign is_crc_byte = (idx == CRC_IDX);

  assign res_valid = item_valid && is_crc_byte;
  assign item_take = item_valid && (!is_crc_byte || res_ready);

  always_comb begin
    if (item.scratch_byte == crc_base) begin
      res.temperature_raw = {msb_r, mask_lsb(lsb_r, res_r)};
      res.check_status    = 1'b0;
    end else begin
      res.temperature_raw = 16'h0000;
      res.check_status    = 1'b1;
    end
  end

  always_comb begin
    crc_nxt = crc_r;
    idx_nxt = idx_r;
    lsb_nxt = lsb_r;
    msb_nxt = msb_r;
    res_nxt = res_r;
    if (item_take) begin
      crc_nxt = crc_base;
      idx_nxt = idx;
      if (idx < CRC_IDX) begin
        crc_nxt = crc8_update(crc_base, item.scratch_byte);
        idx_nxt = idx + 4'd1;
        if (idx == TEMP_LSB_IDX) begin
          lsb_nxt = item.scratch_byte;
        end
        if (idx == TEMP_MSB_IDX) begin
          msb_nxt = item.scratch_byte;
        end
        if (idx == CONFIG_IDX) begin
          res_nxt = res_code_t'(item.scratch_byte[6:5]);
        end
      end else begin
        // The CRC byte closes the frame; later bytes are dropped until a start mark.
        idx_nxt = IDLE_IDX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 8'h00;
      idx_r <= TEMP_LSB_IDX;
      lsb_r <= 8'h00;
      msb_r <= 8'h00;
      res_r <= RES_9BIT;
    end else begin
      crc_r <= crc_nxt;
      idx_r <= idx_nxt;
      lsb_r <= lsb_nxt;
      msb_r <= msb_nxt;
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- src/tsc_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tsc_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_valid,
  input  wire tsc_pkg::result_t res,
  output logic                  res_ready,
  output logic                  out_valid,
  output tsc_pkg::result_t      out_res,
  input  wire logic             out_ready
);
  import tsc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  assign res_ready = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- src/temp_scratchpad_checker.sv -----
// Scratchpad checker for a one-wire temperature sensor.
// in_bus takes one scratchpad byte per item, in bus order; frame_start marks
// the first byte of a scratchpad and restarts the byte count and the CRC.
// A byte that arrives after reset without a mark counts as a first byte.
// The CRC-8 (reflected, polynomial 0x8C) runs over the first eight bytes, and
// the ninth byte is compared with it. out_bus then carries one item: the raw
// temperature with the unused fraction bits cleared and check_status 0, or a
// zero temperature and check_status 1 on a mismatch. Other bytes give none.
// The ninth byte is held in the input register, and its result is then
// registered in the result register once that register is free.
// Throughput: one byte per cycle while out_bus does not hold a result back,
// set by the combinational CRC update between the two registers.
// When out_bus is stalled with a result waiting, bytes that give no result
// still flow; the next ninth byte waits in the input register and in_bus
// stalls behind it. Reset empties both registers and restarts the frame.
`timescale 1ns / 1ps
`default_nettype none

module temp_scratchpad_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  tsc_in_if.sink    in_bus,
  tsc_out_if.source out_bus
);
  import tsc_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     item_take;
  logic     res_valid;
  logic     res_ready;
  result_t  res;
  result_t  out_res;

  assign in_item.scratch_byte = in_bus.scratch_byte;
  assign in_item.frame_start  = in_bus.frame_start;

  tsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  tsc_frame_core u_frame_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res),
    .res_ready  (res_ready)
  );

  tsc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_bus.valid),
    .out_res   (out_res),
    .out_ready (out_bus.ready)
  );

  assign out_bus.temperature_raw = out_res.temperature_raw;
  assign out_bus.check_status    = out_res.check_status;

endmodule

`default_nettype wire

// ----- tb/tsc_frame_checker.sv -----
`timescale 1ns / 1ps

module tsc_frame_checker
  import tsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  tsc_in_if           in_bus,
  tsc_out_if          out_bus,
  output int unsigned fail_count,
  output int unsigned results_seen,
  output int unsigned awaited
);

  logic [7:0] crc_run;
  logic [3:0] next_pos;
  logic [7:0] lsb_kept;
  logic [7:0] msb_kept;
  res_code_t  res_kept;
  result_t    awaited_q[$];

  // Byte-wide form of the reflected CRC: fold the data in first, then shift eight times.
  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic result_t frame_result(input logic [7:0] crc_byte, input logic [7:0] crc,
                                           input logic [7:0] lsb, input logic [7:0] msb,
                                           input res_code_t res);
    result_t r;
    logic [7:0] kept;
    if (crc_byte != crc) begin
      r.temperature_raw = 16'h0000;
      r.check_status    = 1'b1;
    end else begin
      case (res)
        RES_9BIT:  kept = lsb & ~8'b0000_0111;
        RES_10BIT: kept = lsb & ~8'b0000_0011;
        RES_11BIT: kept = lsb & ~8'b0000_0001;
        default:   kept = lsb;
      endcase
      r.temperature_raw = {msb, kept};
      r.check_status    = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    logic [3:0] pos;
    logic [7:0] crc;
    result_t    want;
    if (!rst_n) begin
      crc_run      = 8'h00;
      next_pos     = TEMP_LSB_IDX;
      lsb_kept     = 8'h00;
      msb_kept     = 8'h00;
      res_kept     = RES_9BIT;
      awaited_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        results_seen = results_seen + 1;
        if (awaited_q.size() == 0) begin
          $display("%0t: result with none expected: temperature_raw=%h check_status=%b",
                   $time, out_bus.temperature_raw, out_bus.check_status);
          fail_count = fail_count + 1;
        end else begin
          want = awaited_q.pop_front();
          if (want.temperature_raw !== out_bus.temperature_raw ||
              want.check_status !== out_bus.check_status) begin
            if (want.temperature_raw !== out_bus.temperature_raw) begin
              $display("%0t: temperature_raw expected %h, got %h",
                       $time, want.temperature_raw, out_bus.temperature_raw);
            end
            if (want.check_status !== out_bus.check_status) begin
              $display("%0t: check_status expected %b, got %b",
                       $time, want.check_status, out_bus.check_status);
            end
            fail_count = fail_count + 1;
          end
        end
      end

      if (in_bus.valid && in_bus.ready) begin
        // A start mark drops whatever frame was in progress.
        pos = in_bus.frame_start ? TEMP_LSB_IDX : next_pos;
        crc = in_bus.frame_start ? 8'h00 : crc_run;
        if (pos < CRC_IDX) begin
          crc_run = crc_fold(crc, in_bus.scratch_byte);
          if (pos == TEMP_LSB_IDX) begin
            lsb_kept = in_bus.scratch_byte;
          end else if (pos == TEMP_MSB_IDX) begin
            msb_kept = in_bus.scratch_byte;
          end else if (pos == CONFIG_IDX) begin
            res_kept = res_code_t'(in_bus.scratch_byte[6:5]);
          end
          next_pos = pos + 4'd1;
        end else if (pos == CRC_IDX) begin
          crc_run  = crc;
          next_pos = IDLE_IDX;
          awaited_q.push_back(frame_result(in_bus.scratch_byte, crc, lsb_kept, msb_kept,
                                           res_kept));
        end
      end
    end
    awaited = awaited_q.size();
  end

endmodule

// ----- tb/temp_scratchpad_checker_tb.sv -----
`timescale 1ns / 1ps

module temp_scratchpad_checker_tb;
  import tsc_pkg::*;

  localparam int unsigned ITEM_TARGET  = 1350;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;

  tsc_in_if  in_bus();
  tsc_out_if out_bus();

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned awaited;
  int unsigned items_sent;
  int unsigned idle_cycles;
  bit          quiet_run;
  bit          squeeze_done;
  logic [7:0]  pad [0:8];

  temp_scratchpad_checker u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  tsc_frame_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_bus       (in_bus),
    .out_bus      (out_bus),
    .fail_count   (fail_count),
    .results_seen (results_seen),
    .awaited      (awaited)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic seal_pad(input bit good);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 8; i++) begin
      c = crc8_update(c, pad[i]);
    end
    pad[8] = good ? c : c ^ 8'($urandom_range(1, 255));
  endtask

  task automatic send_byte(input logic [7:0] b, input logic mark, input bit counted);
    int unsigned g;
    g = quiet_run ? 0 : gap_len();
    @(negedge clk);
    if (g != 0) begin
      in_bus.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.scratch_byte <= b;
    in_bus.frame_start  <= mark;
    do @(posedge clk); while (!in_bus.ready);
    if (counted) items_sent++;
  endtask

  task automatic send_pad(input int unsigned n, input logic mark);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(pad[i], (i == 0) ? mark : 1'b0, 1'b1);
    end
  endtask

  // Result side: random ready, with one long hold-off once results are flowing.
  initial begin
    int unsigned g;
    out_bus.ready = 1'b0;
    squeeze_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      out_bus.ready <= 1'b1;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      if (!squeeze_done && results_seen >= 20) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        squeeze_done = 1'b1;
      end else begin
        g = gap_len();
        if (g != 0) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("temp_scratchpad_checker verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned kind;
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.scratch_byte = 8'h00;
    in_bus.frame_start  = 1'b0;
    items_sent          = 0;
    quiet_run           = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // First frame has no start mark; the block must still take it as a frame.
    pad = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h7F, 8'hAA, 8'h55, 8'h80, 8'h00};
    seal_pad(1'b1);
    send_pad(9, 1'b0);
    // Two bytes of a frame, then a start mark cuts in with a frame whose CRC is wrong.
    send_byte(8'h12, 1'b1, 1'b1);
    send_byte(8'h34, 1'b0, 1'b1);
    pad = '{8'h07, 8'h80, 8'h4B, 8'h46, 8'h1F, 8'hFF, 8'h00, 8'h10, 8'h00};
    seal_pad(1'b0);
    send_pad(9, 1'b1);
    // Bytes after the CRC byte with no start mark are dropped.
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      kind      = $urandom_range(0, 99);
      quiet_run = ($urandom_range(0, 3) == 0);
      if (kind < 75) begin
        for (int i = 0; i < 8; i++) pad[i] = 8'($urandom);
        seal_pad($urandom_range(0, 99) < 85);
        send_pad(9, 1'b1);
      end else if (kind < 85) begin
        for (int i = 0; i < 8; i++) pad[i] = 8'($urandom);
        send_pad($urandom_range(1, 8), 1'b1);
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'b0);
      end else begin
        repeat (9) send_byte(8'($urandom), ($urandom_range(0, 9) == 0), 1'b1);
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (awaited == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("temp_scratchpad_checker verification clean");
    end else begin
      $display("temp_scratchpad_checker verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/tsc_pkg.sv
src/tsc_ifs.sv
src/tsc_in_stage.sv
src/tsc_frame_core.sv
src/tsc_out_stage.sv
src/temp_scratchpad_checker.sv
tb/tsc_frame_checker.sv
tb/temp_scratchpad_checker_tb.sv
